### design/sorted_array_priority_queue_defines.svh
// Assertion macros for the sorted array priority queue.
// Included by every file that carries checks; expects clock and reset in scope.
`ifndef SORTED_ARRAY_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_ARRAY_PRIORITY_QUEUE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication or plain property, sampled on clock, off in reset.
`define SPQ_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Next-cycle implication.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SPQ_ASSERT(label, prop, msg)
`define SPQ_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### design/spq_pkg.sv
// Shared types and constants for the sorted array priority queue.
// Used by spq_ctrl, spq_dp and the top level; no dependencies.
package spq_pkg;

   localparam int unsigned CAPACITY_DEF  = 16;
   localparam int unsigned KEY_W         = 32;
   localparam int unsigned COUNT_W       = 5;
   localparam int unsigned LIMIT_W       = 5;
   localparam int unsigned STATUS_W      = 2;
   // largest count the 5-bit limit register can ever allow
   localparam int unsigned COUNT_MAX     = 31;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

   localparam logic OP_ENQ = 1'b0;
   localparam logic OP_DEQ = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic load;   // beat accepted: capture result
      logic op;     // opcode of that beat
      logic enq;    // insert the key into the row
      logic deq;    // pop the head of the row
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;
      logic empty;
   } sts_type;

endpackage

### design/sorted_array_priority_queue.sv
// Sorted array priority queue (min first). Keys sit in an ascending row of
// CAPACITY registers; an insert compares the key against every cell at once and
// the row opens a gap at the first cell that is not smaller (equal keys: newest
// first), a pop shifts the row down by one. Every request beat yields exactly one
// response beat, and a new request is taken every cycle while the
// response side keeps up; the single output register holds one
// result, so the request side stalls only while that result is not taken. The
// cost per beat is set by the row-wide compare and the count/limit compare.
// The limit register (csr_data, reset 16) caps the number of stored keys at the
// smaller of its value and CAPACITY; a limit of zero drops every insert. Write it
// only with no response outstanding. No clearing pass after reset.
// Depends on spq_pkg, spq_ctrl and spq_dp.

module sorted_array_priority_queue #(
   parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value (signed)
   input  logic [0:0]  req_tuser,   // [0] opcode: 0 enqueue, 1 dequeue
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] out_value, [36:32] count, [37] is_empty, rest 0
   output logic [1:0]  rsp_tuser,   // [1:0] status: 0 ok, 1 full, 2 empty
   // limit register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data     // [4:0] capacity_limit
);

   spq_pkg::cmd_type                  cmd;
   spq_pkg::sts_type                  sts;
   logic signed [spq_pkg::KEY_W-1:0]  out_value;
   spq_pkg::status_type               status;
   logic [spq_pkg::COUNT_W-1:0]       count;
   logic                              is_empty;

   // limit register is always writable
   assign csr_ready = 1'b1;

   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser[0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   spq_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_limit (csr_data),
      .cmd       (cmd),
      .req_value (req_tdata),
      .sts       (sts),
      .out_value (out_value),
      .status    (status),
      .count     (count),
      .is_empty  (is_empty)
   );

   assign rsp_tdata = {2'b00, is_empty, count, out_value};
   assign rsp_tuser = status;

endmodule

### design/spq_ctrl.sv
// Handshake controller for the sorted array priority queue.
// Depends on spq_pkg and the assertion macro header.
`include "sorted_array_priority_queue_defines.svh"

module spq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic              req_op,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  spq_pkg::sts_type  sts,
   output spq_pkg::cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_HOLD = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   // a held result leaving this cycle frees the output register
   assign req_tready = (state_ff == ST_IDLE) || rsp_tready;
   assign rsp_tvalid = (state_ff == ST_HOLD);
   assign accept     = req_tvalid && req_tready;

   assign cmd.load = accept;
   assign cmd.op   = req_op;
   assign cmd.enq  = accept && (req_op == spq_pkg::OP_ENQ) && !sts.full;
   assign cmd.deq  = accept && (req_op == spq_pkg::OP_DEQ) && !sts.empty;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (rsp_tready && !accept) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   `SPQ_ASSERT(a_no_overwrite, (rsp_tvalid && !rsp_tready) |-> !accept, "result overwritten")
   `SPQ_ASSERT(a_one_action, !(cmd.enq && cmd.deq), "insert and pop together")
   `SPQ_ASSERT_NEXT(a_accept_shows, accept, rsp_tvalid, "accepted beat gave no result")

endmodule

### design/spq_dp.sv
// Datapath: sorted register row of keys, entry count, limit register, result register.
// Depends on spq_pkg and the assertion macro header.
`include "sorted_array_priority_queue_defines.svh"

module spq_dp #(
   parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write,
   input  logic [spq_pkg::LIMIT_W-1:0]            csr_limit,
   input  spq_pkg::cmd_type                       cmd,
   input  logic signed [spq_pkg::KEY_W-1:0]       req_value,
   output spq_pkg::sts_type                       sts,
   output logic signed [spq_pkg::KEY_W-1:0]       out_value,
   output spq_pkg::status_type                    status,
   output logic [spq_pkg::COUNT_W-1:0]            count,
   output logic                                   is_empty
);

   localparam int unsigned CAP_EFF =
      (CAPACITY < spq_pkg::COUNT_MAX) ? CAPACITY : spq_pkg::COUNT_MAX;

   logic signed [spq_pkg::KEY_W-1:0] entries_ff [CAPACITY];
   logic signed [spq_pkg::KEY_W-1:0] entries_in [CAPACITY];
   logic [CAPACITY-1:0]              lt;

   logic [spq_pkg::COUNT_W-1:0]      count_ff, count_in;
   logic [spq_pkg::LIMIT_W-1:0]      limit_ff;
   logic [spq_pkg::COUNT_W-1:0]      limit_eff;

   logic signed [spq_pkg::KEY_W-1:0] out_value_ff, out_value_in;
   spq_pkg::status_type              status_ff, status_in;

   assign limit_eff = (32'(limit_ff) < 32'(CAP_EFF)) ? limit_ff
                                                     : spq_pkg::COUNT_W'(CAP_EFF);
   assign sts.full  = (count_ff >= limit_eff);
   assign sts.empty = (count_ff == '0);

   // each cell: live and smaller than the key -> stays; first cell not so -> key;
   // later cells take their left neighbour. Pop shifts everything one to the left.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign lt[i] = (32'(count_ff) > 32'(i)) && (entries_ff[i] < req_value);

      always_comb begin
         entries_in[i] = entries_ff[i];
         if (cmd.enq && !lt[i]) begin
            if (i == 0) entries_in[i] = req_value;
            else        entries_in[i] = lt[(i > 0) ? i - 1 : 0] ? req_value
                                                                : entries_ff[(i > 0) ? i - 1 : 0];
         end else if (cmd.deq) begin
            if (i < CAPACITY - 1) entries_in[i] = entries_ff[(i < CAPACITY - 1) ? i + 1 : i];
         end
      end

      always_ff @(posedge clock) begin
         entries_ff[i] <= entries_in[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.enq)      count_in = count_ff + 1'b1;
      else if (cmd.deq) count_in = count_ff - 1'b1;
   end

   always_comb begin
      out_value_in = '0;
      status_in    = spq_pkg::STATUS_OK;
      if (cmd.op == spq_pkg::OP_DEQ) begin
         if (sts.empty) begin
            out_value_in = '1;
            status_in    = spq_pkg::STATUS_EMPTY;
         end else begin
            out_value_in = entries_ff[0];
         end
      end else if (sts.full) begin
         status_in = spq_pkg::STATUS_FULL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         limit_ff <= spq_pkg::LIMIT_RESET;
      end else begin
         count_ff <= count_in;
         if (csr_write) limit_ff <= csr_limit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_value_ff <= out_value_in;
         status_ff    <= status_in;
      end
   end

   // count_ff always reflects the last accepted beat, which is the one on show
   assign out_value = out_value_ff;
   assign status    = status_ff;
   assign count     = count_ff;
   assign is_empty  = (count_ff == '0);

   `SPQ_ASSERT(a_count_bound, 32'(count_ff) <= 32'(CAP_EFF), "count beyond row size")
   `SPQ_ASSERT(a_head_sorted, (count_ff >= 5'd2) |-> (entries_ff[0] <= entries_ff[1]),
               "head of row out of order")
   `SPQ_ASSERT_NEXT(a_enq_count, cmd.enq, count_ff == $past(count_ff) + 1'b1,
                    "insert did not bump count")
   `SPQ_ASSERT_NEXT(a_deq_count, cmd.deq, count_ff == $past(count_ff) - 1'b1,
                    "pop did not drop count")

endmodule

### bench/spq_checker.sv
// Result checker for the sorted array priority queue: watches the request, response
// and limit-write channels, keeps its own sorted row and compares every response beat.
// Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_checker #(
   parameter int unsigned CAPACITY = spq_pkg::CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [0:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [4:0]  csr_data,
   output int unsigned fail_count,
   output int unsigned pending,
   output int unsigned results_seen,
   output int unsigned drops_seen,
   output int unsigned empty_pops_seen
);

   typedef struct packed {
      logic [spq_pkg::KEY_W-1:0]   out_value;
      spq_pkg::status_type         status;
      logic [spq_pkg::COUNT_W-1:0] count;
      logic                        is_empty;
   } pq_result_type;

   logic signed [spq_pkg::KEY_W-1:0] key_row [CAPACITY];
   int unsigned                      row_depth;
   logic [spq_pkg::LIMIT_W-1:0]      cap_limit;
   pq_result_type                    due_results [$];

   // insert or pop on the local row, return the response it should give
   function automatic pq_result_type apply_queue_op(input logic op,
                                                    input logic signed [spq_pkg::KEY_W-1:0] key);
      pq_result_type res;
      int unsigned   cap_now;
      int unsigned   slot;
      int            i;
      res = '0;
      res.status = spq_pkg::STATUS_OK;
      cap_now = (cap_limit < CAPACITY) ? cap_limit : CAPACITY;
      if (op == spq_pkg::OP_ENQ) begin
         if (row_depth >= cap_now) begin
            res.status = spq_pkg::STATUS_FULL;
         end else begin
            slot = 0;
            while (slot < row_depth && key_row[slot] < key) slot++;
            for (i = row_depth; i > slot; i--) key_row[i] = key_row[i-1];
            key_row[slot] = key;
            row_depth++;
         end
      end else begin
         if (row_depth == 0) begin
            res.out_value = '1;
            res.status    = spq_pkg::STATUS_EMPTY;
         end else begin
            res.out_value = key_row[0];
            for (i = 0; i + 1 < row_depth; i++) key_row[i] = key_row[i+1];
            row_depth--;
         end
      end
      res.count    = row_depth[spq_pkg::COUNT_W-1:0];
      res.is_empty = (row_depth == 0);
      return res;
   endfunction

   always @(posedge clock) begin
      pq_result_type want;
      pq_result_type got;
      if (reset) begin
         row_depth = 0;
         cap_limit = spq_pkg::LIMIT_RESET;
         due_results.delete();
      end else begin
         // response first: it can never belong to a request taken on this edge
         if (rsp_tvalid && rsp_tready) begin
            got.out_value = rsp_tdata[31:0];
            got.count     = rsp_tdata[36:32];
            got.is_empty  = rsp_tdata[37];
            got.status    = spq_pkg::status_type'(rsp_tuser);
            results_seen++;
            if (due_results.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: response beat with nothing outstanding: value %0d status %0d",
                           $time, $signed(got.out_value), got.status);
            end else begin
               want = due_results.pop_front();
               if (want.status == spq_pkg::STATUS_FULL)  drops_seen++;
               if (want.status == spq_pkg::STATUS_EMPTY) empty_pops_seen++;
               if (got.out_value !== want.out_value || got.status !== want.status ||
                   got.count !== want.count || got.is_empty !== want.is_empty) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t: result %0d expected value %0d status %0d count %0d",
                               " empty %0d, got value %0d status %0d count %0d empty %0d"},
                              $time, results_seen, $signed(want.out_value), want.status,
                              want.count, want.is_empty, $signed(got.out_value),
                              got.status, got.count, got.is_empty);
               end
            end
         end
         if (csr_valid && csr_ready) cap_limit = csr_data;
         if (req_tvalid && req_tready)
            due_results.push_back(apply_queue_op(req_tuser[0], req_tdata));
      end
      pending = due_results.size();
   end

endmodule

### bench/tb_sorted_array_priority_queue.sv
// Testbench top for the sorted array priority queue: clock, reset, request stimulus,
// response back-pressure, limit writes and the verdict. Depends on spq_pkg,
// spq_checker and the sorted_array_priority_queue RTL.
`timescale 1ns / 1ps

module tb_sorted_array_priority_queue;

   localparam int unsigned LONG_HOLD = 300;   // receiver hold-off, in cycles

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // [31:0] value (signed)
   logic [0:0]  req_tuser;    // [0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;    // [31:0] out_value, [36:32] count, [37] is_empty
   logic [1:0]  rsp_tuser;    // [1:0] status
   logic        csr_valid;
   logic        csr_ready;
   logic [4:0]  csr_data;     // [4:0] capacity_limit

   int unsigned fail_count, pending, results_seen, drops_seen, empty_pops_seen;
   int unsigned beats_sent;
   bit          steady;       // no idling on either side while set
   bit          hold_req;     // raised here, cleared by the receiver after its hold-off

   sorted_array_priority_queue DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   spq_checker queue_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data),
      .fail_count      (fail_count),
      .pending         (pending),
      .results_seen    (results_seen),
      .drops_seen      (drops_seen),
      .empty_pops_seen (empty_pops_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs
   initial begin
      #20_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   // idle length: mostly none or short, now and then long
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // keys: full range, a narrow band for plenty of ties, and the extremes
   function automatic logic [31:0] pick_key();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 5) return $urandom;
      if (r < 8) return 32'($urandom_range(0, 15)) - 32'd8;
      case ($urandom_range(0, 3))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   // response side: random ready, with the odd long hold-off on request
   initial begin
      int unsigned idle_left;
      rsp_tready = 1'b0;
      idle_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_tready = 1'b0;
            repeat (LONG_HOLD - 1) @(negedge clock);
            hold_req = 1'b0;
         end else if (steady) begin
            rsp_tready = 1'b1;
         end else if (idle_left > 0) begin
            rsp_tready = 1'b0;
            idle_left--;
         end else begin
            rsp_tready = 1'b1;
            idle_left  = pick_gap();
         end
      end
   end

   // one request beat, after a random idle unless in a steady stretch
   task automatic push_item(input logic op, input logic [31:0] key);
      int unsigned gap;
      gap = steady ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = op;
      req_tdata  = key;
      do @(posedge clock); while (!req_tready);
      beats_sent++;
   endtask

   // park the request side until every outstanding response has come back
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // limit writes only with the queue idle; every request gives a response,
   // so nothing is still in flight once the outstanding list is empty
   task automatic write_limit(input logic [4:0] lim);
      wait_drained();
      csr_valid = 1'b1;
      csr_data  = lim;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // random phase: insert bias swings every 40 beats so the row fills and drains
   task automatic run_phase(input logic [4:0] lim, input int unsigned n_items,
                            input bit with_hold);
      int unsigned enq_pct;
      int unsigned i;
      write_limit(lim);
      for (i = 0; i < n_items; i++) begin
         enq_pct = ((i / 40) % 2 == 0) ? 70 : 35;
         steady  = (i % 100 >= 60 && i % 100 < 80);
         if (with_hold && i == 50) hold_req = 1'b1;  // block must fill and stall
         if (i == 120) wait_drained();               // sender pause mid-phase
         push_item(($urandom_range(0, 99) < enq_pct) ? spq_pkg::OP_ENQ : spq_pkg::OP_DEQ,
                   pick_key());
      end
      steady = 1'b0;
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = spq_pkg::OP_ENQ;
      csr_valid  = 1'b0;
      csr_data   = '0;
      steady     = 1'b0;
      hold_req   = 1'b0;
      beats_sent = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed, on the reset limit: pop on empty, extremes, a tie
      push_item(spq_pkg::OP_DEQ, 32'h0);
      push_item(spq_pkg::OP_ENQ, 32'h7FFF_FFFF);
      push_item(spq_pkg::OP_ENQ, 32'h8000_0000);
      push_item(spq_pkg::OP_ENQ, 32'h0000_0000);
      push_item(spq_pkg::OP_ENQ, 32'hFFFF_FFFF);
      push_item(spq_pkg::OP_ENQ, 32'd5);
      push_item(spq_pkg::OP_ENQ, 32'd5);
      repeat (7) push_item(spq_pkg::OP_DEQ, 32'hFFFF_FFFF);   // last one finds it empty
      // small limit: third insert is dropped
      write_limit(5'd2);
      push_item(spq_pkg::OP_ENQ, 32'd7);
      push_item(spq_pkg::OP_ENQ, 32'd3);
      push_item(spq_pkg::OP_ENQ, 32'd9);
      push_item(spq_pkg::OP_DEQ, 32'h0);
      push_item(spq_pkg::OP_DEQ, 32'h0);
      // zero limit drops everything
      write_limit(5'd0);
      push_item(spq_pkg::OP_ENQ, 32'd4);
      // limit lowered below the stored count: keys stay, inserts drop
      write_limit(5'd3);
      push_item(spq_pkg::OP_ENQ, 32'd30);
      push_item(spq_pkg::OP_ENQ, 32'd10);
      push_item(spq_pkg::OP_ENQ, 32'd20);
      write_limit(5'd1);
      push_item(spq_pkg::OP_ENQ, 32'd40);
      push_item(spq_pkg::OP_DEQ, 32'h0);
      push_item(spq_pkg::OP_DEQ, 32'h0);
      push_item(spq_pkg::OP_ENQ, 32'd50);
      push_item(spq_pkg::OP_DEQ, 32'h0);
      push_item(spq_pkg::OP_ENQ, 32'd60);
      push_item(spq_pkg::OP_DEQ, 32'h0);

      // random phases; a limit above the row size acts as the row size
      run_phase(5'd16, 220, 1'b1);
      run_phase(5'd31, 220, 1'b0);
      run_phase(5'd1, 150, 1'b0);
      run_phase(5'd0, 40, 1'b0);
      run_phase(5'd5, 200, 1'b1);
      run_phase(5'd17, 200, 1'b0);
      run_phase(5'($urandom_range(1, 16)), 200, 1'b0);
      run_phase(5'd16, 170, 1'b0);

      // drain, then wait on for any stray beat
      steady = 1'b1;
      wait_drained();
      repeat (20) @(posedge clock);

      $display("covered %0d request beats and %0d response beats on limits 0 to 31",
               beats_sent, results_seen);
      $display("of which %0d inserts were dropped as full and %0d pops hit an empty queue",
               drops_seen, empty_pops_seen);
      if (fail_count == 0 && pending == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
